// ----- rtl/adcws_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, register and mode codes, and Q.24 scaling constants for the
// ADC window-sum scaler. No dependencies; imported by every file but adcws_ram.
package adcws_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int SUM_W         = 16;
    localparam int SCALED_W      = 12;
    localparam int TENTHS_W      = 9;
    localparam int CHANNELS      = 3;
    localparam int WINDOW_DEPTH  = 10;
    localparam int CFG_ADDR_W    = 4;
    localparam int CFG_DATA_W    = 32;

    // Q.24 arithmetic widths: gain, sum x gain product, signed accumulator
    localparam int GAIN_W = 20;
    localparam int PROD_W = SUM_W + GAIN_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int FRAC_W = 24;

    localparam logic [GAIN_W-1:0] GAIN_MA =
        GAIN_W'(((64'd660 << 24) + 64'd6142) / 64'd12285);
    localparam logic [GAIN_W-1:0] GAIN_V =
        GAIN_W'(((64'd14399 << 24) + 64'd136500) / 64'd273000);
    localparam logic [GAIN_W-1:0] GAIN_SUP = GAIN_W'(1036288);

    localparam logic signed [ACC_W-1:0] OFFS_MA =
        ACC_W'(((64'd399672 << 24) + 64'd6142) / 64'd12285);
    localparam logic signed [ACC_W-1:0] OFFS_V   = ACC_W'(64'd330 << 24);
    localparam logic signed [ACC_W-1:0] HALF_Q   = ACC_W'(64'd1 << 23);
    localparam logic signed [ACC_W-1:0] MA_LIMIT = ACC_W'(64'd2047 << 24);

    localparam logic [SUM_W-1:0]    CONTACT_LIMIT = SUM_W'(20480);
    localparam logic [SCALED_W-1:0] MA_CLAMP      = SCALED_W'(2047);
    localparam logic [9:0]          SUP_THRESHOLD = 10'd52;
    localparam logic [9:0]          SUP_DIODE     = 10'd14;

    // floor(n / 10) for any 16-bit n: (n * 52429) >> 19
    localparam logic [16:0] RECIP_TEN = 17'd52429;
    localparam int          RECIP_SH  = 19;
    localparam int          TENTH_W   = 13;

    typedef enum logic [1:0] {
        MODE_CONTACT = 2'd0,
        MODE_CURRENT = 2'd1,
        MODE_VOLTAGE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_FIRST_MODE  = 2'd0,
        REG_SECOND_MODE = 2'd1,
        REG_SUPPLY_EN   = 2'd2
    } cfg_reg_t;

    function automatic logic [GAIN_W-1:0] input_gain(input logic [1:0] mode);
        logic [GAIN_W-1:0] g;
        case (mode)
            MODE_CURRENT: g = GAIN_MA;
            MODE_VOLTAGE: g = GAIN_V;
            default:      g = '0;
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/adcws_in_if.sv -----
`timescale 1ns / 1ps
// Sample channel: valid/ready handshake carrying three 12-bit ADC readings.
// Depends on adcws_pkg for the field widths.
interface adcws_in_if import adcws_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] first_sample;
    logic [SAMPLE_W-1:0] second_sample;
    logic [SAMPLE_W-1:0] supply_sample;

    modport source (
        output valid, first_sample, second_sample, supply_sample,
        input  ready
    );

    modport sink (
        input  valid, first_sample, second_sample, supply_sample,
        output ready
    );

endinterface

// ----- rtl/adcws_out_if.sv -----
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying window sums and scaled values.
// Depends on adcws_pkg for the field widths.
interface adcws_out_if import adcws_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic [SUM_W-1:0]           first_window_sum;
    logic [SUM_W-1:0]           second_window_sum;
    logic [SUM_W-1:0]           supply_window_sum;
    logic signed [SCALED_W-1:0] first_scaled;
    logic signed [SCALED_W-1:0] second_scaled;
    logic [TENTHS_W-1:0]        supply_tenths;

    modport source (
        output valid, first_window_sum, second_window_sum, supply_window_sum,
               first_scaled, second_scaled, supply_tenths,
        input  ready
    );

    modport sink (
        input  valid, first_window_sum, second_window_sum, supply_window_sum,
               first_scaled, second_scaled, supply_tenths,
        output ready
    );

endinterface

// ----- rtl/adc_window_sum_input_scaler_core.sv -----
`timescale 1ns / 1ps
// Top level of the ADC window-sum scaler: sample ring RAM, running sums,
// Q.24 scaling pipeline and APB register file. Uses adcws_pkg, adcws_ram,
// adcws_in_if and adcws_out_if.

// One sample transfer per clock is taken unless a stalled output holds it. Its
// result reaches the output register after the ring read, registered at the
// accepting edge; then the running-sum update, the gain multiply and the final scaling
// each take one more stage. The ring memory does one read-modify-write of a
// slot per transfer (old triple read, new triple written in the same cycle).
// The ring reads as zero after reset through one fill flag per slot, so no
// clearing pass is needed and the block is ready in the first cycle after
// reset. Mode and enable registers sit at byte addresses 0, 4 and 8 and must
// only be written while no transfer is in flight. A stalled result holds in
// the output register while up to three more transfers advance behind it.
module adc_window_sum_input_scaler_core import adcws_pkg::*; #(
    parameter int WINDOW = WINDOW_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    adcws_in_if.sink              samples,
    adcws_out_if.source           results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WORD_W = CHANNELS * SAMPLE_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    // ---------------------------------------------------------------- config
    logic [1:0] first_mode_reg;
    logic [1:0] second_mode_reg;
    logic       supply_en_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_mode_reg  <= '0;
            second_mode_reg <= '0;
            supply_en_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_FIRST_MODE:  first_mode_reg  <= pwdata[1:0];
                REG_SECOND_MODE: second_mode_reg <= pwdata[1:0];
                REG_SUPPLY_EN:   supply_en_reg   <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FIRST_MODE:  prdata = {{(CFG_DATA_W-2){1'b0}}, first_mode_reg};
            REG_SECOND_MODE: prdata = {{(CFG_DATA_W-2){1'b0}}, second_mode_reg};
            REG_SUPPLY_EN:   prdata = {{(CFG_DATA_W-1){1'b0}}, supply_en_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------ handshakes
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s2_adv, s3_adv, out_adv;
    logic in_fire;

    assign out_adv = !out_valid_reg || results.ready;
    assign s3_adv  = !s3_valid_reg  || out_adv;
    assign s2_adv  = !s2_valid_reg  || s3_adv;

    assign samples.ready = !s1_valid_reg || s2_adv;
    assign in_fire       = samples.valid && samples.ready;
    assign results.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (samples.ready)
            begin
                s1_valid_reg <= in_fire;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------- ring read-modify-write
    logic [SLOT_W-1:0] slot_reg;
    logic [WINDOW-1:0] filled_reg;
    logic [WORD_W-1:0] fresh_word;
    logic [WORD_W-1:0] old_word;
    logic [WORD_W-1:0] s1_fresh_reg;
    logic              s1_filled_reg;

    assign fresh_word = {samples.supply_sample, samples.second_sample,
                         samples.first_sample};

    adcws_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (in_fire),
        .waddr (slot_reg),
        .wdata (fresh_word),
        .re    (in_fire),
        .raddr (slot_reg),
        .rdata (old_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            filled_reg <= '0;
        end
        else if (in_fire)
        begin
            filled_reg[slot_reg] <= 1'b1;
            slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_fresh_reg  <= fresh_word;
            s1_filled_reg <= filled_reg[slot_reg];
        end
    end

    // ---------------------------------------------------------- running sums
    logic [SUM_W-1:0] sum_reg  [CHANNELS];
    logic [SUM_W-1:0] sum_next [CHANNELS];
    logic [SUM_W-1:0] s2_sum_reg [CHANNELS];
    logic             s2_load;

    assign s2_load = s1_valid_reg && s2_adv;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            // an unfilled slot reads as zero
            sum_next[c] = sum_reg[c]
                - (s1_filled_reg ? SUM_W'(old_word[c*SAMPLE_W +: SAMPLE_W]) : '0)
                + SUM_W'(s1_fresh_reg[c*SAMPLE_W +: SAMPLE_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else if (s2_load)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                s2_sum_reg[c] <= sum_next[c];
            end
        end
    end

    // -------------------------------------------------------- gain multiply
    logic [SUM_W-1:0]   s3_sum_reg [CHANNELS];
    logic [PROD_W-1:0]  s3_prod_a_reg;
    logic [PROD_W-1:0]  s3_prod_b_reg;
    logic [TENTH_W-1:0] s3_tenth_reg;
    logic [SUM_W+16:0]  recip_prod;
    logic               s3_load;

    assign s3_load    = s2_valid_reg && s3_adv;
    assign recip_prod = s2_sum_reg[2] * RECIP_TEN;

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                s3_sum_reg[c] <= s2_sum_reg[c];
            end
            s3_prod_a_reg <= s2_sum_reg[0] * input_gain(first_mode_reg);
            s3_prod_b_reg <= s2_sum_reg[1] * input_gain(second_mode_reg);
            s3_tenth_reg  <= recip_prod[RECIP_SH +: TENTH_W];
        end
    end

    // -------------------------------------------------------------- finalize
    function automatic logic [SCALED_W-1:0] finish_scale(
        input logic [1:0]        mode,
        input logic [SUM_W-1:0]  sum,
        input logic [PROD_W-1:0] prod
    );
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] mag;
        logic [SCALED_W-1:0]     q;
        logic [SCALED_W-1:0]     r;
        acc = '0;
        mag = '0;
        q   = '0;
        case (mode)
            MODE_CONTACT:
            begin
                r = (sum > CONTACT_LIMIT) ? '0 : SCALED_W'(1);
            end
            MODE_CURRENT:
            begin
                acc = signed'({2'b00, prod}) - OFFS_MA;
                mag = acc + HALF_Q;
                if (acc > MA_LIMIT)
                begin
                    r = MA_CLAMP;
                end
                else if (acc[ACC_W-1])
                begin
                    r = '0;
                end
                else
                begin
                    r = mag[FRAC_W +: SCALED_W];
                end
            end
            MODE_VOLTAGE:
            begin
                // truncate toward zero on the magnitude, then restore sign
                acc = signed'({2'b00, prod}) - OFFS_V + HALF_Q;
                mag = acc[ACC_W-1] ? -acc : acc;
                q   = mag[FRAC_W +: SCALED_W];
                r   = acc[ACC_W-1] ? -q : q;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    logic [SUM_W-1:0]           out_sum_reg [CHANNELS];
    logic [SCALED_W-1:0]        out_a_reg;
    logic [SCALED_W-1:0]        out_b_reg;
    logic [TENTHS_W-1:0]        out_tenths_reg;
    logic [TENTH_W+GAIN_W:0]    sup_acc;
    logic [9:0]                 sup_volts;
    logic [9:0]                 sup_adj;
    logic                       out_load;

    assign out_load  = s3_valid_reg && out_adv;
    assign sup_acc   = s3_tenth_reg * GAIN_SUP + (TENTH_W+GAIN_W+1)'(HALF_Q);
    assign sup_volts = sup_acc[FRAC_W +: 10];
    assign sup_adj   = (sup_volts >= SUP_THRESHOLD) ? sup_volts + SUP_DIODE : sup_volts;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                out_sum_reg[c] <= s3_sum_reg[c];
            end
            out_a_reg      <= finish_scale(first_mode_reg, s3_sum_reg[0], s3_prod_a_reg);
            out_b_reg      <= finish_scale(second_mode_reg, s3_sum_reg[1], s3_prod_b_reg);
            out_tenths_reg <= supply_en_reg ? sup_adj[TENTHS_W-1:0] : '0;
        end
    end

    assign results.first_window_sum  = out_sum_reg[0];
    assign results.second_window_sum = out_sum_reg[1];
    assign results.supply_window_sum = out_sum_reg[2];
    assign results.first_scaled      = signed'(out_a_reg);
    assign results.second_scaled     = signed'(out_b_reg);
    assign results.supply_tenths     = out_tenths_reg;

    // ------------------------------------------------------------ assertions
    // stage 1 relies on the RAM read register: no new read while it holds
    a_s1_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_adv |-> !samples.ready)
        else $error("sample accepted while ring read data still pending");

    a_slot_marked_filled: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> filled_reg[$past(slot_reg)])
        else $error("written ring slot not marked filled");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> slot_reg <= LAST_SLOT)
        else $error("ring slot pointer out of range");

endmodule

// ----- rtl/adcws_ram.sv -----
`timescale 1ns / 1ps
// Generic single-clock RAM, one write and one registered read port.
// A read and a write to the same address in one cycle return the old word.
module adcws_ram #(
    parameter  int WIDTH  = 36,
    parameter  int DEPTH  = 10,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
